/* sv/addressable_led_strip_driver_macros.svh */
// Assertion macros shared by the LED strip driver modules.
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_MACROS_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ALSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ALSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/alsd_pkg.sv */
// Shared types, constants and command structures of the LED strip driver.
`default_nettype none

package alsd_pkg;

  localparam int unsigned MAX_LEDS_DEF = 64;
  localparam int unsigned PIXEL_W      = 24;
  localparam int unsigned BIT_PTR_W    = 5;
  localparam int unsigned TICK_W       = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [BIT_PTR_W-1:0] LAST_BIT = BIT_PTR_W'(PIXEL_W - 1);

  localparam logic [6:0]  LED_COUNT_RST  = 7'd25;
  localparam logic [7:0]  ZERO_HIGH_RST  = 8'd29;
  localparam logic [7:0]  ZERO_LOW_RST   = 8'd61;
  localparam logic [7:0]  ONE_HIGH_RST   = 8'd58;
  localparam logic [7:0]  ONE_LOW_RST    = 8'd32;
  localparam logic [15:0] LATCH_RST      = 16'd4320;

  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_SET_PIXEL = 3'd1,
    KIND_SET_ALL   = 3'd2,
    KIND_CLEAR     = 3'd3,
    KIND_SHOW      = 3'd4
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LED_COUNT = 3'd0,
    REG_ZERO_HIGH = 3'd1,
    REG_ZERO_LOW  = 3'd2,
    REG_ONE_HIGH  = 3'd3,
    REG_ONE_LOW   = 3'd4,
    REG_LATCH     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    WORD_HOLD  = 2'd0,
    WORD_SHIFT = 2'd1,
    WORD_FIRST = 2'd2,
    WORD_NEXT  = 2'd3
  } word_op_e;

  typedef enum logic [2:0] {
    CNT_HOLD  = 3'd0,
    CNT_DEC   = 3'd1,
    CNT_HIGH  = 3'd2,
    CNT_LOW   = 3'd3,
    CNT_LATCH = 3'd4,
    CNT_CLEAR = 3'd5
  } cnt_op_e;

  typedef struct packed {
    logic     rd_head;
    logic     pix_we;
    logic     sweep_start;
    logic     sweep_zero;
    logic     sweep_we;
    word_op_e word_op;
    cnt_op_e  cnt_op;
  } cmd_t;

  typedef struct packed {
    logic head_fresh;
    logic idx_ok;
    logic count_zero;
    logic next_end;
    logic tick_last;
    logic bit_last;
    logic sweep_last;
  } status_t;

endpackage

`default_nettype wire

/* sv/alsd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module alsd_ram #(
  parameter int unsigned WIDTH = alsd_pkg::PIXEL_W,
  parameter int unsigned DEPTH = alsd_pkg::MAX_LEDS_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/alsd_datapath.sv */
// Datapath: configuration registers, pixel store, shift word and timing counters.
`default_nettype none
`include "addressable_led_strip_driver_macros.svh"

module alsd_datapath #(
  parameter int unsigned MAX_LEDS = alsd_pkg::MAX_LEDS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [alsd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [alsd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic [7:0]                        pixel_index_i,
  input  wire logic [7:0]                        red_i,
  input  wire logic [7:0]                        green_i,
  input  wire logic [7:0]                        blue_i,
  input  wire alsd_pkg::cmd_t                    cmd_i,
  output alsd_pkg::status_t                      status_o
);

  localparam int unsigned PTR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LEDS + 1);
  localparam int unsigned CMP_W = (CNT_W > 8) ? CNT_W : 8;

  logic [6:0]  led_count_q;
  logic [7:0]  zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [15:0] latch_q;

  logic [alsd_pkg::PIXEL_W-1:0]   word_q, word_d;
  logic [alsd_pkg::BIT_PTR_W-1:0] bit_q, bit_d;
  logic [PTR_W-1:0]               ptr_q, ptr_d;
  logic [alsd_pkg::TICK_W-1:0]    tick_q, tick_d;
  logic [PTR_W-1:0]               sweep_q, sweep_d;
  logic [alsd_pkg::PIXEL_W-1:0]   fill_q, fill_d;
  logic                           fresh_q, fresh_d;

  logic [CMP_W-1:0]             active;
  logic [CMP_W-1:0]             led_ext;
  logic [CMP_W-1:0]             max_ext;
  logic                         ram_we;
  logic [PTR_W-1:0]             ram_waddr;
  logic [PTR_W-1:0]             ram_raddr;
  logic [alsd_pkg::PIXEL_W-1:0] ram_wdata;
  logic [alsd_pkg::PIXEL_W-1:0] ram_rdata;
  logic [alsd_pkg::PIXEL_W-1:0] color;

  function automatic logic [alsd_pkg::TICK_W-1:0] min_one(input logic [alsd_pkg::TICK_W-1:0] v);
    return (v == '0) ? alsd_pkg::TICK_W'(1) : v;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= alsd_pkg::LED_COUNT_RST;
      zero_high_q <= alsd_pkg::ZERO_HIGH_RST;
      zero_low_q  <= alsd_pkg::ZERO_LOW_RST;
      one_high_q  <= alsd_pkg::ONE_HIGH_RST;
      one_low_q   <= alsd_pkg::ONE_LOW_RST;
      latch_q     <= alsd_pkg::LATCH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        alsd_pkg::REG_LED_COUNT: led_count_q <= cfg_data_i[6:0];
        alsd_pkg::REG_ZERO_HIGH: zero_high_q <= cfg_data_i[7:0];
        alsd_pkg::REG_ZERO_LOW:  zero_low_q  <= cfg_data_i[7:0];
        alsd_pkg::REG_ONE_HIGH:  one_high_q  <= cfg_data_i[7:0];
        alsd_pkg::REG_ONE_LOW:   one_low_q   <= cfg_data_i[7:0];
        alsd_pkg::REG_LATCH:     latch_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // A count above the store size is taken as the store size.
  assign led_ext = CMP_W'(led_count_q);
  assign max_ext = CMP_W'(MAX_LEDS);
  assign active  = (led_ext > max_ext) ? max_ext : led_ext;
  assign color   = {green_i, red_i, blue_i};

  always_comb begin
    word_d = word_q;
    bit_d  = bit_q;
    ptr_d  = ptr_q;
    unique case (cmd_i.word_op)
      alsd_pkg::WORD_HOLD: ;
      alsd_pkg::WORD_SHIFT: begin
        word_d = {word_q[alsd_pkg::PIXEL_W-2:0], 1'b0};
        bit_d  = bit_q + alsd_pkg::BIT_PTR_W'(1);
      end
      alsd_pkg::WORD_FIRST: begin
        word_d = ram_rdata;
        bit_d  = '0;
        ptr_d  = '0;
      end
      alsd_pkg::WORD_NEXT: begin
        word_d = ram_rdata;
        bit_d  = '0;
        ptr_d  = ptr_q + PTR_W'(1);
      end
      default: ;
    endcase
  end

  // A high period takes its length from the bit about to go out, a low period
  // from the bit that just went out.
  always_comb begin
    tick_d = tick_q;
    unique case (cmd_i.cnt_op)
      alsd_pkg::CNT_HOLD:  ;
      alsd_pkg::CNT_DEC:   tick_d = tick_q - alsd_pkg::TICK_W'(1);
      alsd_pkg::CNT_HIGH:  tick_d = min_one(alsd_pkg::TICK_W'(
                             word_d[alsd_pkg::PIXEL_W-1] ? one_high_q : zero_high_q));
      alsd_pkg::CNT_LOW:   tick_d = min_one(alsd_pkg::TICK_W'(
                             word_q[alsd_pkg::PIXEL_W-1] ? one_low_q : zero_low_q));
      alsd_pkg::CNT_LATCH: tick_d = min_one(latch_q);
      alsd_pkg::CNT_CLEAR: tick_d = '0;
      default: ;
    endcase
  end

  always_comb begin
    sweep_d = sweep_q;
    fill_d  = fill_q;
    if (cmd_i.sweep_start) begin
      sweep_d = '0;
      fill_d  = cmd_i.sweep_zero ? '0 : color;
    end else if (cmd_i.sweep_we) begin
      sweep_d = sweep_q + PTR_W'(1);
    end
  end

  assign ram_we    = cmd_i.pix_we | cmd_i.sweep_we;
  assign ram_waddr = cmd_i.sweep_we ? sweep_q : PTR_W'(pixel_index_i);
  assign ram_wdata = cmd_i.sweep_we ? fill_q : color;
  assign ram_raddr = cmd_i.rd_head ? '0 : ptr_q + PTR_W'(1);
  // Read data holds pixel 0 only after a read of it with no write alongside.
  assign fresh_d   = cmd_i.rd_head & ~ram_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q  <= '0;
      bit_q   <= '0;
      ptr_q   <= '0;
      tick_q  <= '0;
      sweep_q <= '0;
      fill_q  <= '0;
      fresh_q <= 1'b0;
    end else begin
      word_q  <= word_d;
      bit_q   <= bit_d;
      ptr_q   <= ptr_d;
      tick_q  <= tick_d;
      sweep_q <= sweep_d;
      fill_q  <= fill_d;
      fresh_q <= fresh_d;
    end
  end

  alsd_ram #(
    .WIDTH (alsd_pkg::PIXEL_W),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.head_fresh = fresh_q;
  assign status_o.idx_ok     = CMP_W'(pixel_index_i) < active;
  assign status_o.count_zero = active == '0;
  assign status_o.next_end   = (CMP_W'(ptr_q) + CMP_W'(1)) >= active;
  assign status_o.tick_last  = tick_q <= alsd_pkg::TICK_W'(1);
  assign status_o.bit_last   = bit_q == alsd_pkg::LAST_BIT;
  assign status_o.sweep_last = sweep_q == PTR_W'(MAX_LEDS - 1);

  `ALSD_ASSERT_IMPL(a_dec_above_one, cmd_i.cnt_op == alsd_pkg::CNT_DEC, tick_q > alsd_pkg::TICK_W'(1), "tick counter decremented at its last tick")
  `ALSD_ASSERT_IMPL(a_shift_in_pixel, cmd_i.word_op == alsd_pkg::WORD_SHIFT, bit_q != alsd_pkg::LAST_BIT, "shift past the last bit of a pixel")
  `ALSD_ASSERT_IMPL(a_pix_we_in_range, cmd_i.pix_we, status_o.idx_ok, "pixel written at an index beyond the count")

endmodule

`default_nettype wire

/* sv/alsd_ctrl.sv */
// Controller: send-phase state machine, store sweep sequencing and result register.
`default_nettype none
`include "addressable_led_strip_driver_macros.svh"

module alsd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [2:0]        kind_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   line_level_o,
  output logic                   busy_res_o,
  output logic                   rejected_o,
  output alsd_pkg::cmd_t         cmd_o,
  input  wire alsd_pkg::status_t status_i
);

  typedef enum logic [4:0] {
    ST_SWEEP = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HIGH  = 5'b00100,
    ST_LOW   = 5'b01000,
    ST_LATCH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   line_q, busy_q, rej_q;
  logic   slot_free, acc, busy_now, rej, kind_cmd;

  assign slot_free = ~out_valid_q | out_ready_i;
  assign busy_now  = (state_q == ST_HIGH) | (state_q == ST_LOW) | (state_q == ST_LATCH);
  assign kind_cmd  = (kind_i >= alsd_pkg::KIND_SET_PIXEL) & (kind_i <= alsd_pkg::KIND_SHOW);

  // A show is held off while the first pixel's read data is stale.
  assign in_ready_o = slot_free & (state_q != ST_SWEEP) &
                      ~((state_q == ST_IDLE) & (kind_i == alsd_pkg::KIND_SHOW) &
                        ~status_i.head_fresh);
  assign acc = in_valid_i & in_ready_o;

  always_comb begin
    state_d             = state_q;
    rej                 = 1'b0;
    // The latch period needs no pixel data, so it already reads pixel 0 again.
    cmd_o.rd_head       = (state_q != ST_HIGH) & (state_q != ST_LOW);
    cmd_o.pix_we        = 1'b0;
    cmd_o.sweep_start   = 1'b0;
    cmd_o.sweep_zero    = 1'b0;
    cmd_o.sweep_we      = 1'b0;
    cmd_o.word_op       = alsd_pkg::WORD_HOLD;
    cmd_o.cnt_op        = alsd_pkg::CNT_HOLD;
    unique case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_we = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (kind_i)
            alsd_pkg::KIND_SET_PIXEL: begin
              if (status_i.idx_ok) begin
                cmd_o.pix_we = 1'b1;
              end else begin
                rej = 1'b1;
              end
            end
            alsd_pkg::KIND_SET_ALL: begin
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_SWEEP;
            end
            alsd_pkg::KIND_CLEAR: begin
              cmd_o.sweep_start = 1'b1;
              cmd_o.sweep_zero  = 1'b1;
              state_d           = ST_SWEEP;
            end
            alsd_pkg::KIND_SHOW: begin
              if (status_i.count_zero) begin
                cmd_o.cnt_op = alsd_pkg::CNT_LATCH;
                state_d      = ST_LATCH;
              end else begin
                cmd_o.word_op = alsd_pkg::WORD_FIRST;
                cmd_o.cnt_op  = alsd_pkg::CNT_HIGH;
                state_d       = ST_HIGH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_HIGH: begin
        if (acc) begin
          rej = kind_cmd;
          if (status_i.tick_last) begin
            cmd_o.cnt_op = alsd_pkg::CNT_LOW;
            state_d      = ST_LOW;
          end else begin
            cmd_o.cnt_op = alsd_pkg::CNT_DEC;
          end
        end
      end
      ST_LOW: begin
        if (acc) begin
          rej = kind_cmd;
          if (!status_i.tick_last) begin
            cmd_o.cnt_op = alsd_pkg::CNT_DEC;
          end else if (!status_i.bit_last) begin
            cmd_o.word_op = alsd_pkg::WORD_SHIFT;
            cmd_o.cnt_op  = alsd_pkg::CNT_HIGH;
            state_d       = ST_HIGH;
          end else if (status_i.next_end) begin
            cmd_o.cnt_op = alsd_pkg::CNT_LATCH;
            state_d      = ST_LATCH;
          end else begin
            cmd_o.word_op = alsd_pkg::WORD_NEXT;
            cmd_o.cnt_op  = alsd_pkg::CNT_HIGH;
            state_d       = ST_HIGH;
          end
        end
      end
      ST_LATCH: begin
        if (acc) begin
          rej = kind_cmd;
          if (status_i.tick_last) begin
            cmd_o.cnt_op = alsd_pkg::CNT_CLEAR;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.cnt_op = alsd_pkg::CNT_DEC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // After reset the store is swept to zero before any request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      line_q <= state_d == ST_HIGH;
      busy_q <= (state_d == ST_HIGH) | (state_d == ST_LOW) | (state_d == ST_LATCH);
      rej_q  <= rej;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = line_q;
  assign busy_res_o   = busy_q;
  assign rejected_o   = rej_q;

  `ALSD_ASSERT_IMPL(a_store_write_idle, cmd_o.pix_we || cmd_o.sweep_we, state_q == ST_IDLE || state_q == ST_SWEEP, "pixel store written while a frame is sent")
  `ALSD_ASSERT_IMPL(a_no_take_on_stall, out_valid_o && !out_ready_i, !(in_valid_i && in_ready_o), "request taken while the result is stalled")
  `ALSD_ASSERT_IMPL(a_high_is_busy, out_valid_o && line_level_o, busy_res_o, "line high outside a frame")
  `ALSD_ASSERT_NEXT(a_fill_sweeps, acc && state_q == ST_IDLE && (kind_i == alsd_pkg::KIND_SET_ALL || kind_i == alsd_pkg::KIND_CLEAR), state_q == ST_SWEEP, "fill request did not start a sweep")

endmodule

`default_nettype wire

/* sv/addressable_led_strip_driver.sv */
// Top level of the addressable LED strip driver.
//
// Each request on the input channel is one tick of the line timing and may
// carry a command: set one pixel, set all pixels, clear all pixels or show.
// Each request gives exactly one result: the line level after the tick, a
// busy flag for frame and latch time, and a flag for an ignored command.
// The result sits in an output register from the cycle after the request is taken;
// a new request is taken in the same cycle the waiting result is taken, so
// ticks and show frames run at one request per cycle. A stalled receiver
// holds the result and stops the input, and timing only advances on requests.
// Set all and clear write the store one entry per cycle through its single
// write port, so the input stalls after such a request until every entry
// is written. A show right after a store write waits for the registered
// read of pixel 0. Reset clears the control state and then sweeps the store
// to zero, with no request taken until every entry is written; configuration
// writes are taken at any time, and take effect on the next timing segment.
`default_nettype none

module addressable_led_strip_driver #(
  parameter int unsigned MAX_LEDS = alsd_pkg::MAX_LEDS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [alsd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [alsd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [2:0]                      kind_i,
  input  wire logic [7:0]                      pixel_index_i,
  input  wire logic [7:0]                      red_i,
  input  wire logic [7:0]                      green_i,
  input  wire logic [7:0]                      blue_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 line_level_o,
  output logic                                 busy_res_o,
  output logic                                 rejected_o
);

  alsd_pkg::cmd_t    cmd;
  alsd_pkg::status_t status;

  alsd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  alsd_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_index_i (pixel_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
// Testbench of the LED strip driver: directed and random tick streams checked against a line model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET = 900;
  localparam int unsigned STORE_DEPTH = alsd_pkg::MAX_LEDS_DEF;
  // The directed show row and the rows after it run under short timings.
  localparam int          FRAME_ROW   = 11;

  // Kinds outside the command set act as plain ticks.
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

  typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_LATCH} line_phase_e;
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic line;
    logic busy;
    logic rejected;
  } line_sample_t;

  typedef struct packed {
    logic [2:0]   kind;
    logic [7:0]   index;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic         fixed;
    line_sample_t want;
  } strip_vector_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [alsd_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [alsd_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [2:0]                      kind_i = '0;
  logic [7:0]                      pixel_index_i = '0;
  logic [7:0]                      red_i = '0;
  logic [7:0]                      green_i = '0;
  logic [7:0]                      blue_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            line_level_o;
  logic                            busy_res_o;
  logic                            rejected_o;

  // Line model state and its copy of the settings.
  logic [23:0] pixel_colors [STORE_DEPTH];
  line_phase_e line_phase = LINE_IDLE;
  int          pixel_at = 0;
  logic [4:0]  bit_at = '0;
  logic [15:0] ticks_left = '0;
  logic [23:0] shift_colors = '0;
  logic        line_out = 1'b0;
  logic [6:0]  cur_led_count = alsd_pkg::LED_COUNT_RST;
  logic [7:0]  cur_zero_high = alsd_pkg::ZERO_HIGH_RST;
  logic [7:0]  cur_zero_low = alsd_pkg::ZERO_LOW_RST;
  logic [7:0]  cur_one_high = alsd_pkg::ONE_HIGH_RST;
  logic [7:0]  cur_one_low = alsd_pkg::ONE_LOW_RST;
  logic [15:0] cur_latch = alsd_pkg::LATCH_RST;

  line_sample_t samples_due [$];
  line_sample_t want_s;
  line_sample_t got_s;
  logic         fixed_valid = 1'b0;
  line_sample_t fixed_sample = '0;
  int unsigned  fail_count = 0;
  int unsigned  stall_cycles = 0;
  int unsigned  sent_items = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;

  strip_vector_t directed_vectors [17] = '{
    // kind, index, red, green, blue, fixed, {line, busy, rejected}
    '{alsd_pkg::KIND_TICK,      8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 3'b000},
    '{alsd_pkg::KIND_SET_PIXEL, 8'd0,   8'h0F, 8'hA5, 8'hF0, 1'b1, 3'b000},
    '{alsd_pkg::KIND_SET_PIXEL, 8'd24,  8'hFF, 8'hFF, 8'hFF, 1'b1, 3'b000},
    '{alsd_pkg::KIND_SET_PIXEL, 8'd25,  8'h12, 8'h34, 8'h56, 1'b1, 3'b001},
    '{alsd_pkg::KIND_SET_PIXEL, 8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'b001},
    '{KIND_UNUSED_LO,           8'd3,   8'h00, 8'hFF, 8'h00, 1'b1, 3'b000},
    '{KIND_UNUSED_HI,           8'd255, 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'b000},
    '{alsd_pkg::KIND_SET_ALL,   8'd0,   8'hFF, 8'hFF, 8'hFF, 1'b1, 3'b000},
    '{alsd_pkg::KIND_CLEAR,     8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 3'b000},
    '{alsd_pkg::KIND_SET_PIXEL, 8'd0,   8'h0F, 8'hA5, 8'hF0, 1'b1, 3'b000},
    '{alsd_pkg::KIND_SET_PIXEL, 8'd1,   8'h80, 8'h01, 8'h7F, 1'b1, 3'b000},
    '{alsd_pkg::KIND_SHOW,      8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 3'b110},
    '{alsd_pkg::KIND_SET_PIXEL, 8'd2,   8'h11, 8'h22, 8'h33, 1'b0, 3'b000},
    '{alsd_pkg::KIND_SET_ALL,   8'd0,   8'hFF, 8'h00, 8'hFF, 1'b0, 3'b000},
    '{alsd_pkg::KIND_CLEAR,     8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
    '{alsd_pkg::KIND_SHOW,      8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 3'b000},
    '{KIND_UNUSED_LO,           8'd9,   8'h55, 8'hAA, 8'h55, 1'b0, 3'b000}
  };

  addressable_led_strip_driver i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .pixel_index_i(pixel_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .line_level_o (line_level_o),
    .busy_res_o   (busy_res_o),
    .rejected_o   (rejected_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [15:0] at_least_one(logic [15:0] v);
    return (v == '0) ? 16'd1 : v;
  endfunction

  function automatic int active_leds();
    return (int'(cur_led_count) > int'(STORE_DEPTH)) ? int'(STORE_DEPTH) : int'(cur_led_count);
  endfunction

  function automatic void line_start_latch();
    line_phase = LINE_LATCH;
    ticks_left = at_least_one(cur_latch);
    line_out = 1'b0;
  endfunction

  function automatic void line_start_high();
    line_phase = LINE_HIGH;
    ticks_left = at_least_one(16'(shift_colors[23] ? cur_one_high : cur_zero_high));
    line_out = 1'b1;
  endfunction

  function automatic void line_start_pixel(int p);
    if (p >= active_leds()) begin
      line_start_latch();
    end else begin
      pixel_at = p;
      bit_at = '0;
      shift_colors = pixel_colors[p];
      line_start_high();
    end
  endfunction

  function automatic void line_advance();
    if (ticks_left > 16'd1) begin
      ticks_left = ticks_left - 16'd1;
      return;
    end
    case (line_phase)
      LINE_HIGH: begin
        line_phase = LINE_LOW;
        ticks_left = at_least_one(16'(shift_colors[23] ? cur_one_low : cur_zero_low));
        line_out = 1'b0;
      end
      LINE_LOW: begin
        if (bit_at < alsd_pkg::LAST_BIT) begin
          bit_at = bit_at + 5'd1;
          shift_colors = {shift_colors[22:0], 1'b0};
          line_start_high();
        end else begin
          line_start_pixel(pixel_at + 1);
        end
      end
      LINE_LATCH: begin
        line_phase = LINE_IDLE;
        ticks_left = '0;
        line_out = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // One tick of the strip: applies the command and returns the line after it.
  function automatic line_sample_t strip_tick(logic [2:0] k, logic [7:0] idx,
                                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
    line_sample_t s;
    s.rejected = 1'b0;
    if (line_phase != LINE_IDLE) begin
      s.rejected = (k >= alsd_pkg::KIND_SET_PIXEL && k <= alsd_pkg::KIND_SHOW);
      line_advance();
    end else begin
      case (k)
        alsd_pkg::KIND_SET_PIXEL: begin
          if (int'(idx) < active_leds()) pixel_colors[idx] = {g, r, b};
          else s.rejected = 1'b1;
        end
        alsd_pkg::KIND_SET_ALL: foreach (pixel_colors[p]) pixel_colors[p] = {g, r, b};
        alsd_pkg::KIND_CLEAR:   foreach (pixel_colors[p]) pixel_colors[p] = '0;
        alsd_pkg::KIND_SHOW:    line_start_pixel(0);
        default: ;
      endcase
    end
    s.line = line_out;
    s.busy = (line_phase != LINE_IDLE);
    return s;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] short_ticks();
    return 8'($urandom_range(3));
  endfunction

  function automatic void set_idling(idle_mode_e m);
    case (m)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 49; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default:       begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        want_s = strip_tick(kind_i, pixel_index_i, red_i, green_i, blue_i);
        if (fixed_valid) want_s = fixed_sample;
        samples_due.push_back(want_s);
      end
      if (out_valid_o && out_ready_i) begin
        got_s = '{line_level_o, busy_res_o, rejected_o};
        if (samples_due.size() == 0) begin
          $error("result arrived with no request waiting for it");
          fail_count++;
        end else begin
          want_s = samples_due.pop_front();
          if (got_s.line !== want_s.line) begin
            $error("line_level: expected %0b, got %0b", want_s.line, got_s.line);
            fail_count++;
          end
          if (got_s.busy !== want_s.busy) begin
            $error("busy_res: expected %0b, got %0b", want_s.busy, got_s.busy);
            fail_count++;
          end
          if (got_s.rejected !== want_s.rejected) begin
            $error("rejected: expected %0b, got %0b", want_s.rejected, got_s.rejected);
            fail_count++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAIL addressable_led_strip_driver");
          $finish;
        end
      end
    end
  end

  // Called and returns at a falling edge; the request is taken in between.
  task automatic send_request(input logic [2:0] k, input logic [7:0] idx,
                              input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    pixel_index_i <= idx;
    red_i         <= r;
    green_i       <= g;
    blue_i        <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_items++;
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    send_request(3'($urandom), any_byte(), any_byte(), any_byte(), any_byte());
  endtask

  task automatic finish_frame();
    while (line_phase != LINE_IDLE) begin
      send_request(alsd_pkg::KIND_TICK, any_byte(), any_byte(), any_byte(), any_byte());
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (samples_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input alsd_pkg::cfg_reg_e which, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    case (which)
      alsd_pkg::REG_LED_COUNT: cur_led_count = value[6:0];
      alsd_pkg::REG_ZERO_HIGH: cur_zero_high = value[7:0];
      alsd_pkg::REG_ZERO_LOW:  cur_zero_low  = value[7:0];
      alsd_pkg::REG_ONE_HIGH:  cur_one_high  = value[7:0];
      alsd_pkg::REG_ONE_LOW:   cur_one_low   = value[7:0];
      alsd_pkg::REG_LATCH:     cur_latch     = value;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Upper data bits beyond each register's width are junk and must be dropped.
  task automatic load_settings(input logic [6:0] count, input logic [7:0] zh,
                               input logic [7:0] zl, input logic [7:0] oh,
                               input logic [7:0] ol, input logic [15:0] latch);
    write_reg(alsd_pkg::REG_LED_COUNT, {9'($urandom), count});
    write_reg(alsd_pkg::REG_ZERO_HIGH, {8'($urandom), zh});
    write_reg(alsd_pkg::REG_ZERO_LOW,  {8'($urandom), zl});
    write_reg(alsd_pkg::REG_ONE_HIGH,  {8'($urandom), oh});
    write_reg(alsd_pkg::REG_ONE_LOW,   {8'($urandom), ol});
    write_reg(alsd_pkg::REG_LATCH,     latch);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Fill some pixels, usually show them, and keep ticking until the latch ends.
  task automatic run_sequence(input bit allow_show);
    int eff;
    int n;
    int pick;
    eff = active_leds();
    n = $urandom_range(6, 1);
    for (int s = 0; s < n; s++) begin
      pick = $urandom_range(99);
      if (pick < 65 && eff > 0) begin
        send_request(alsd_pkg::KIND_SET_PIXEL, 8'($urandom_range(eff - 1)),
                     any_byte(), any_byte(), any_byte());
      end else if (pick < 72) begin
        send_request(alsd_pkg::KIND_SET_ALL, any_byte(), any_byte(), any_byte(),
                     any_byte());
      end else if (pick < 77) begin
        send_request(alsd_pkg::KIND_CLEAR, any_byte(), any_byte(), any_byte(), any_byte());
      end else begin
        send_noise();
      end
    end
    if (allow_show && $urandom_range(99) < 85) begin
      send_request(alsd_pkg::KIND_SHOW, any_byte(), any_byte(), any_byte(), any_byte());
    end
    while (line_phase != LINE_IDLE) begin
      if ($urandom_range(99) < 8) begin
        send_noise();
      end else begin
        send_request(alsd_pkg::KIND_TICK, any_byte(), any_byte(), any_byte(), any_byte());
      end
    end
  endtask

  initial begin
    int sequences;
    bit show_ok;
    foreach (pixel_colors[p]) pixel_colors[p] = '0;
    set_idling(IDLE_NONE);
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_vectors[v]) begin
      // A short two-pixel frame keeps the directed show brief.
      if (v == FRAME_ROW) begin
        drain_results();
        load_settings(7'd2, 8'd1, 8'd2, 8'd2, 8'd1, 16'd3);
      end
      fixed_valid  = directed_vectors[v].fixed;
      fixed_sample = directed_vectors[v].want;
      send_request(directed_vectors[v].kind, directed_vectors[v].index,
                   directed_vectors[v].red, directed_vectors[v].green,
                   directed_vectors[v].blue);
    end
    fixed_valid = 1'b0;

    for (int stage = 0; stage < 8 || sent_items < ITEM_TARGET; stage++) begin
      finish_frame();
      drain_results();
      set_idling(idle_mode_e'(stage % 4));
      case (stage)
        0: load_settings(7'd64, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        1: load_settings(7'd1, 8'd1, 8'd3, 8'd2, 8'd1, 16'h0100);
        2: load_settings(7'd127, short_ticks(), short_ticks(), short_ticks(),
                         short_ticks(), 16'd1);
        3: load_settings(7'd0, short_ticks(), short_ticks(), short_ticks(),
                         short_ticks(), 16'd0);
        default: load_settings(7'($urandom_range(2, 1)), short_ticks(), short_ticks(),
                               short_ticks(), short_ticks(), 16'($urandom_range(20)));
      endcase
      // Full-store counts are used without a show; long frames get one sequence.
      show_ok   = (stage != 0 && stage != 2);
      sequences = (stage == 1 || stage >= 4) ? 1 : 4;
      for (int s = 0; s < sequences; s++) begin
        if ($urandom_range(99) < 5) drain_results();
        run_sequence(show_ok);
      end
    end

    finish_frame();
    drain_results();
    repeat (16) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS addressable_led_strip_driver");
    end else begin
      $display("FAIL addressable_led_strip_driver");
    end
    $finish;
  end

endmodule

/* addressable_led_strip_driver.f */
+incdir+sv
sv/alsd_pkg.sv
sv/alsd_ram.sv
sv/alsd_datapath.sv
sv/alsd_ctrl.sv
sv/addressable_led_strip_driver.sv
test/testbench.sv
